// File: design/mgod_pkg.sv
// ============================================================================
// mgod_pkg - shared types and constants
// Item formats, channel sizing and queue depth for the gate onset delay unit.
// ============================================================================
package mgod_pkg;

    // Number of channels with state (1..64).
    localparam int CHANNELS    = 16;
    localparam int CH_IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    // Depth of the queue between front and back (power of two).
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [23:0] SPM_RESET = 24'd3145728;  // 48.0 in Q8.16
    localparam logic [47:0] ROUND_HALF = 48'h00_0000_800000;

    typedef logic [CH_IDX_W-1:0] t_ch_idx;

    // Input beat.
    typedef struct packed {
        logic [3:0]         channel;
        logic signed [23:0] gate_in;
        logic [23:0]        delay_ms;
    } t_in_item;

    // Result beat.
    typedef struct packed {
        logic [3:0]         out_channel;
        logic signed [23:0] gate_out;
    } t_out_item;

    // Classified item handed from front to back.
    typedef struct packed {
        logic [3:0]  channel;
        logic [23:0] gate;
        logic        open;
        logic [23:0] samps;
    } t_work_item;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// File: design/mgod_front.sv
// ============================================================================
// mgod_front - intake and delay conversion
// Holds the rate register, scales the delay and classifies the gate.
// ============================================================================
module mgod_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [23:0]          i_cfg_wdata,
    input  logic                 i_push,
    output logic                 o_full,
    input  mgod_pkg::t_in_item   i_item,
    input  mgod_pkg::t_q_stat    i_q_stat,
    output logic                 o_q_push,
    output mgod_pkg::t_work_item o_q_item
);

    logic [23:0] r_spm;
    logic        r_vld;
    logic [3:0]  r_ch;
    logic [23:0] r_gate;
    logic [47:0] r_prod;
    logic [47:0] n_prod;
    logic [47:0] rounded;
    logic        accept;

    assign o_full   = r_vld & i_q_stat.full;
    assign accept   = i_push & ~o_full;
    assign n_prod   = 48'(i_item.delay_ms) * 48'(r_spm);
    assign o_q_push = r_vld & ~i_q_stat.full;

    // Round half up to a whole sample count.
    assign rounded  = r_prod + mgod_pkg::ROUND_HALF;

    always_comb begin
        o_q_item.channel = r_ch;
        o_q_item.gate    = r_gate;
        o_q_item.open    = (r_gate != 24'd0);
        o_q_item.samps   = rounded[47:24];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spm <= mgod_pkg::SPM_RESET;
            r_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_spm <= i_cfg_wdata;
            end
            if (accept) begin
                r_vld <= 1'b1;
            end else if (!i_q_stat.full) begin
                r_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ch   <= i_item.channel;
            r_gate <= i_item.gate_in;
            r_prod <= n_prod;
        end
    end

endmodule

// File: design/mgod_queue.sv
// ============================================================================
// mgod_queue - work item queue
// Small first-in first-out buffer between front and back.
// ============================================================================
module mgod_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  mgod_pkg::t_work_item i_data,
    input  logic                 i_pop,
    output mgod_pkg::t_work_item o_data,
    output mgod_pkg::t_q_stat    o_stat
);

    mgod_pkg::t_work_item r_mem [mgod_pkg::QUEUE_DEPTH];
    logic [mgod_pkg::QPTR_W-1:0] r_wp;
    logic [mgod_pkg::QPTR_W-1:0] r_rp;
    logic [mgod_pkg::QPTR_W:0]   r_cnt;

    assign o_stat.full  = (r_cnt == (mgod_pkg::QPTR_W+1)'(mgod_pkg::QUEUE_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_data       = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// File: design/mgod_back.sv
// ============================================================================
// mgod_back - per-channel timers and result buffer
// Updates channel state for each work item and buffers two results.
// ============================================================================
module mgod_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mgod_pkg::t_work_item i_q_item,
    input  mgod_pkg::t_q_stat    i_q_stat,
    output logic                 o_q_pop,
    output logic                 o_empty,
    input  logic                 i_pop,
    output mgod_pkg::t_out_item  o_result
);

    logic        r_open    [mgod_pkg::CHANNELS];
    logic [23:0] r_held    [mgod_pkg::CHANNELS];
    logic [31:0] r_elapsed [mgod_pkg::CHANNELS];

    mgod_pkg::t_out_item r_ob [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    mgod_pkg::t_ch_idx idx;
    logic        in_range;
    logic        rising;
    logic [23:0] eff_held;
    logic [31:0] eff_elapsed;
    logic [31:0] n_elapsed;
    logic [23:0] res_gate;
    logic        out_pop;
    logic        room;

    assign out_pop = i_pop & ~o_empty;
    assign room    = (r_cnt != 2'd2) | out_pop;
    assign o_q_pop = ~i_q_stat.empty & room;
    assign o_empty = (r_cnt == 2'd0);
    assign o_result = r_ob[r_rp];

    assign idx      = mgod_pkg::t_ch_idx'(i_q_item.channel);
    assign in_range = (7'(i_q_item.channel) < 7'(mgod_pkg::CHANNELS));

    always_comb begin
        rising      = ~r_open[idx] & i_q_item.open;
        eff_held    = rising ? i_q_item.gate : r_held[idx];
        eff_elapsed = rising ? 32'd0 : r_elapsed[idx];
        if (!i_q_item.open) begin
            n_elapsed = 32'd0;
        end else if (eff_elapsed == 32'hFFFF_FFFF) begin
            n_elapsed = eff_elapsed;
        end else begin
            n_elapsed = eff_elapsed + 32'd1;
        end
        if (in_range && i_q_item.open && (eff_elapsed >= {8'd0, i_q_item.samps})) begin
            res_gate = eff_held;
        end else begin
            res_gate = 24'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < mgod_pkg::CHANNELS; i++) begin
                r_open[i] <= 1'b0;
            end
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (o_q_pop && in_range) begin
                r_open[idx] <= i_q_item.open;
            end
            if (o_q_pop) begin
                r_wp <= ~r_wp;
            end
            if (out_pop) begin
                r_rp <= ~r_rp;
            end
            case ({o_q_pop, out_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop && in_range) begin
            r_held[idx]    <= eff_held;
            r_elapsed[idx] <= n_elapsed;
        end
        if (o_q_pop) begin
            r_ob[r_wp].out_channel <= i_q_item.channel;
            r_ob[r_wp].gate_out    <= res_gate;
        end
    end

endmodule

// File: design/multichannel_gate_onset_delay_unit.sv
// ============================================================================
// multichannel_gate_onset_delay_unit - per-channel on-delay gate timer
// Delays the onset of a gate signal per channel by a programmable time.
// ============================================================================
// Usage:
//   Input queue side: drive i_item and raise push; the beat is taken on an
//   edge where push is high and full is low. Each beat carries a channel,
//   a gate sample and a delay in ms (Q16.8).
//   Result queue side: while empty is low, o_result holds the oldest
//   result; raise pop to take it. Exactly one result per input beat, in
//   order, echoing the channel.
//   Configuration: i_cfg_we with i_cfg_wdata writes samples per ms (Q8.16);
//   write only while the unit is idle.
// Timing:
//   One beat per cycle sustained while pop keeps up. Each beat passes
//   the multiply register, work queue, then the per-channel update
//   into the result buffer. The 24x24 delay scaling multiplier and
//   the single read-modify-write of channel state set the cycle.
// Reset:
//   Synchronous, active low. Clears all channel timers, empties both
//   queues and reloads the rate register with 48 kHz.
// Stalls:
//   With pop low, the two-entry result buffer and the four-entry work
//   queue fill up, after which full rises and input stops cleanly.
// ============================================================================
module multichannel_gate_onset_delay_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [23:0]         i_cfg_wdata,
    input  logic                push,
    output logic                full,
    input  mgod_pkg::t_in_item  i_item,
    output logic                empty,
    input  logic                pop,
    output mgod_pkg::t_out_item o_result
);

    logic                 q_push;
    logic                 q_pop;
    mgod_pkg::t_work_item q_in;
    mgod_pkg::t_work_item q_out;
    mgod_pkg::t_q_stat    q_stat;

    // Front: take the beat, scale the delay, classify the gate.
    mgod_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_push      (push),
        .o_full      (full),
        .i_item      (i_item),
        .i_q_stat    (q_stat),
        .o_q_push    (q_push),
        .o_q_item    (q_in)
    );

    // Decouple intake from the per-channel update.
    mgod_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_stat  (q_stat)
    );

    // Back: advance the channel timer and hold results for the receiver.
    mgod_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_item (q_out),
        .i_q_stat (q_stat),
        .o_q_pop  (q_pop),
        .o_empty  (empty),
        .i_pop    (pop),
        .o_result (o_result)
    );

    // Reset leaves both sides drained and open for input.
    a_reset_clean: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not drained after reset");

    // A waiting result is never dropped while the receiver stalls.
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> !empty)
        else $error("result lost under stall");

    // A channel without state always reports a closed gate.
    a_range_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (7'(o_result.out_channel) >= 7'(mgod_pkg::CHANNELS)))
        |-> (o_result.gate_out == 24'd0))
        else $error("gate output on channel without state");

endmodule
